### hw/rtl/upd_pkg.sv
// Shared types, character constants and helper functions of the percent decoder.
package upd_pkg;

  // Escape tracking phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result queue sizing: one item causes at most three results.
  localparam int RES_MAX     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LCNT_W      = $clog2(RES_MAX + 1);

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       error;
  } upd_result_t;

  // The results caused by one item, in order, with their number.
  typedef struct packed {
    upd_result_t [RES_MAX-1:0] item;
    logic [LCNT_W-1:0]         count;
  } upd_list_t;

  // Decoder state carried from one item to the next.
  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] first_digit;
    logic       discarding;
  } upd_state_t;

  // Status of the result queue as seen by the top level.
  typedef struct packed {
    logic             can_take;
    logic             not_empty;
    logic [CNT_W-1:0] fill;
  } upd_queue_status_t;

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Nibble value of a hex digit; zero for anything else.
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Append one result to a list; a full list stays as it is.
  function automatic upd_list_t list_push(upd_list_t l, logic [7:0] b, logic has,
                                          logic err);
    upd_list_t r;
    r = l;
    if (r.count != LCNT_W'(RES_MAX)) begin
      r.item[r.count[PTR_W-1:0]].data     = has ? b : 8'd0;
      r.item[r.count[PTR_W-1:0]].has_byte = has;
      r.item[r.count[PTR_W-1:0]].last     = 1'b0;
      r.item[r.count[PTR_W-1:0]].error    = err;
      r.count = r.count + LCNT_W'(1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/upd_if.sv
// Stream interfaces for encoded input bytes and decoded results.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink (input valid, input byte_in, input last_in, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       has_byte;
  logic       last_out;
  logic       error_out;

  modport source (output valid, output byte_out, output has_byte, output last_out,
                  output error_out, input ready);
  modport sink (input valid, input byte_out, input has_byte, input last_out,
                input error_out, output ready);
endinterface

### hw/rtl/upd_decoder.sv
// Per-byte decode logic: results caused by one input byte and the next state.
module upd_decoder (
  input  upd_pkg::upd_state_t cur,
  input  logic                strict,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output upd_pkg::upd_list_t  results,
  output upd_pkg::upd_state_t nxt
);
  import upd_pkg::*;

  // Resolve a malformed escape: an error in strict mode, literals otherwise.
  function automatic upd_list_t emit_malformed(upd_list_t l, logic strict_m, logic two,
                                               logic [7:0] fd);
    upd_list_t r;
    r = l;
    if (strict_m) begin
      r = list_push(r, 8'd0, 1'b0, 1'b1);
    end else begin
      r = list_push(r, CH_PCT, 1'b1, 1'b0);
      if (two) begin
        r = list_push(r, fd, 1'b1, 1'b0);
      end
    end
    return r;
  endfunction

  logic       b_hex;
  logic       fresh;
  logic [7:0] plain_byte;
  upd_list_t  l;

  assign b_hex      = is_hex(byte_in);
  assign plain_byte = (byte_in == CH_PLUS) ? CH_SPACE : byte_in;

  // Walk through the escape phases for this byte.
  always_comb begin
    l     = '0;
    nxt   = cur;
    fresh = 1'b0;
    if (cur.discarding) begin
      fresh = 1'b0;
    end else if (cur.phase == PH_PCT) begin
      if (b_hex) begin
        nxt.first_digit = byte_in;
        nxt.phase       = PH_DIGIT;
      end else begin
        l         = emit_malformed(l, strict, 1'b0, cur.first_digit);
        nxt.phase = PH_IDLE;
        if (strict) begin
          nxt.discarding = 1'b1;
        end else begin
          fresh = 1'b1;
        end
      end
    end else if (cur.phase == PH_DIGIT) begin
      if (b_hex) begin
        l = list_push(l, {hex_nibble(cur.first_digit), hex_nibble(byte_in)}, 1'b1, 1'b0);
        nxt.phase       = PH_IDLE;
        nxt.first_digit = 8'd0;
      end else begin
        l         = emit_malformed(l, strict, 1'b1, cur.first_digit);
        nxt.phase = PH_IDLE;
        if (strict) begin
          nxt.discarding = 1'b1;
        end else begin
          fresh = 1'b1;
        end
      end
    end else begin
      nxt.phase = PH_IDLE;
      fresh     = 1'b1;
    end

    // A byte taken with no escape pending.
    if (fresh) begin
      if (byte_in == CH_PCT) begin
        nxt.phase = PH_PCT;
      end else begin
        l = list_push(l, plain_byte, 1'b1, 1'b0);
      end
    end

    // End of message closes any pending escape and marks the final result.
    if (last_in) begin
      if (!nxt.discarding && (nxt.phase != PH_IDLE)) begin
        l = emit_malformed(l, strict, nxt.phase == PH_DIGIT, nxt.first_digit);
      end
      if (l.count == '0) begin
        l = list_push(l, 8'd0, 1'b0, 1'b0);
      end
      l.item[PTR_W'(l.count - LCNT_W'(1))].last = 1'b1;
      nxt = '0;
    end
  end

  assign results = l;

endmodule

### hw/rtl/upd_result_fifo.sv
// Small result queue: takes up to three results at once and hands out one per transfer.
module upd_result_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  upd_pkg::upd_list_t         wr_list,
  input  logic                       rd_en,
  output upd_pkg::upd_result_t       head,
  output upd_pkg::upd_queue_status_t status
);
  import upd_pkg::*;

  upd_result_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   wr_count;
  logic               pop;

  assign pop      = rd_en && (fill != '0);
  assign wr_count = wr_en ? CNT_W'(wr_list.count) : '0;

  // Storage: each written result goes to the next free slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < RES_MAX; i++) begin
        if (LCNT_W'(i) < wr_list.count) begin
          mem[wr_ptr + PTR_W'(i)] <= wr_list.item[i];
        end
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + wr_count - CNT_W'(pop);
    end
  end

  assign head             = mem[rd_ptr];
  assign status.not_empty = (fill != '0);
  assign status.can_take  = (fill <= CNT_W'(QUEUE_DEPTH - RES_MAX));
  assign status.fill      = fill;

endmodule

### hw/rtl/url_percent_decoder.sv
// Results pass through the result queue to the output. Throughput: one byte per cycle
// while each byte gives at most one result and the output is not stalled; a byte that
// gives two or three results holds the output for that many transfers, set by the
// single-read result queue. Input is taken while the queue holds at most one result.
// Reset (synchronous, active high) clears the escape state, strict_mode and the queue.
module url_percent_decoder (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  logic              strict_mode;
  upd_state_t        state;
  upd_state_t        state_next;
  upd_list_t         results;
  upd_result_t       head;
  upd_queue_status_t q_status;
  logic              in_xfer;

  assign in_ch.ready = q_status.can_take;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_mode <= cfg_wr_data;
    end
  end

  // Escape state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  upd_decoder u_decoder (
    .cur     (state),
    .strict  (strict_mode),
    .byte_in (in_ch.byte_in),
    .last_in (in_ch.last_in),
    .results (results),
    .nxt     (state_next)
  );

  upd_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_xfer),
    .wr_list (results),
    .rd_en   (out_ch.ready),
    .head    (head),
    .status  (q_status)
  );

  // Output channel straight from the queue head.
  assign out_ch.valid     = q_status.not_empty;
  assign out_ch.byte_out  = head.data;
  assign out_ch.has_byte  = head.has_byte;
  assign out_ch.last_out  = head.last;
  assign out_ch.error_out = head.error;

endmodule

### hw/rtl/upd_checker.sv
// Port-level checks of the percent decoder and the bind that attaches them.
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_out,
  input logic       has_byte,
  input logic       last_out,
  input logic       error_out
);

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // An error result never carries a byte.
  a_error_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_out) |-> !has_byte)
    else $error("error result carries a byte");

  // A result with neither byte nor error only closes a message.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte && !error_out) |-> last_out)
    else $error("empty result not marked last");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(byte_out) && $stable(has_byte) && $stable(last_out) &&
       $stable(error_out)))
    else $error("stalled result changed");

endmodule

bind url_percent_decoder upd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .byte_out  (out_ch.byte_out),
  .has_byte  (out_ch.has_byte),
  .last_out  (out_ch.last_out),
  .error_out (out_ch.error_out)
);
